>>> hw/rtl/dns_pkg.sv
`timescale 1ns / 1ps

package dns_pkg;

   // directory geometry
   localparam int MAX_ENTRIES = 2048;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int INDEX_W     = 11;
   localparam int COUNT_W     = 12;
   localparam int NAME_LEN    = 8;
   localparam int NAME_W      = 8 * NAME_LEN;

   // item function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // name compare constants
   localparam logic [7:0] MARK_MASK  = 8'h7f;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
   localparam logic [7:0] CASE_GAP   = 8'd32;

   // controller to datapath commands
   typedef struct packed {
      logic wr_en;
      logic start;
      logic scan;
      logic capture;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
   } sts_type;

   // fold a-z to upper case
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         r = c - CASE_GAP;
      end
      return r;
   endfunction

   // compare stored name to query, stopping at the first zero query byte
   function automatic logic names_equal(input logic [NAME_W-1:0] stored,
                                        input logic [NAME_W-1:0] query);
      logic       eq;
      logic       stop;
      logic [7:0] s;
      logic [7:0] q;
      eq   = 1'b1;
      stop = 1'b0;
      for (int k = 0; k < NAME_LEN; k++) begin
         s = stored[8*k +: 8];
         q = query[8*k +: 8];
         if (k == 0) begin
            s = s & MARK_MASK;
         end
         s = fold_upper(s);
         q = fold_upper(q);
         if (!stop) begin
            if (s != q) begin
               eq   = 1'b0;
               stop = 1'b1;
            end else if (q == 8'h00) begin
               stop = 1'b1;
            end
         end
      end
      return eq;
   endfunction

endpackage

>>> hw/rtl/dns_req_if.sv
`timescale 1ns / 1ps

interface dns_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [dns_pkg::INDEX_W-1:0]  entry_index;
   logic [dns_pkg::NAME_W-1:0]   name_bytes;

   modport source (output valid, output func, output entry_index, output name_bytes,
                   input ready);
   modport sink   (input valid, input func, input entry_index, input name_bytes,
                   output ready);
endinterface

>>> hw/rtl/dns_rsp_if.sv
`timescale 1ns / 1ps

interface dns_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [dns_pkg::INDEX_W-1:0]  match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink   (input valid, input found, input match_index, output ready);
endinterface

>>> hw/rtl/dns_ram.sv
`timescale 1ns / 1ps

module dns_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dns_ctrl.sv
`timescale 1ns / 1ps

module dns_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dns_pkg::cmd_type cmd,
   input  dns_pkg::sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == dns_pkg::FUNC_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               cmd.capture = 1'b1;
               state_in    = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/dns_dpath.sv
`timescale 1ns / 1ps

module dns_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [dns_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic [dns_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [dns_pkg::NAME_W-1:0]   req_name_bytes,
   output logic                         rsp_found,
   output logic [dns_pkg::INDEX_W-1:0]  rsp_match_index,
   input  dns_pkg::cmd_type             cmd,
   output dns_pkg::sts_type             sts
);

   logic [dns_pkg::COUNT_W-1:0] entry_count_ff;
   logic [dns_pkg::COUNT_W-1:0] limit;
   logic [dns_pkg::COUNT_W-1:0] remain_ff;
   logic [dns_pkg::COUNT_W-1:0] remain_in;
   logic [dns_pkg::COUNT_W-1:0] remain_dec;
   logic [dns_pkg::NAME_W-1:0]  query_ff;
   logic [dns_pkg::ADDR_W-1:0]  rd_idx_ff;
   logic [dns_pkg::ADDR_W-1:0]  rd_idx_in;
   logic                        rd_vld_ff;
   logic                        rd_vld_in;
   logic [dns_pkg::NAME_W-1:0]  rd_data;
   logic                        wr_ok;
   logic                        hit;
   logic                        res_found_ff;
   logic [dns_pkg::INDEX_W-1:0] res_idx_ff;
   logic                        out_found_ff;
   logic [dns_pkg::INDEX_W-1:0] out_idx_ff;

   // entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // saturate count to the table depth
   assign limit = (32'(entry_count_ff) > dns_pkg::MAX_ENTRIES)
                  ? dns_pkg::COUNT_W'(dns_pkg::MAX_ENTRIES) : entry_count_ff;

   // writes beyond the table are dropped
   assign wr_ok = cmd.wr_en && (32'(req_entry_index) < dns_pkg::MAX_ENTRIES);

   assign remain_dec = remain_ff - dns_pkg::COUNT_W'(1);

   dns_ram #(
      .WIDTH (dns_pkg::NAME_W),
      .DEPTH (dns_pkg::MAX_ENTRIES)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (req_entry_index[dns_pkg::ADDR_W-1:0]),
      .wr_data (req_name_bytes),
      .rd_addr (remain_dec[dns_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // compare the slot read in the previous cycle
   assign hit           = rd_vld_ff && dns_pkg::names_equal(rd_data, query_ff);
   assign sts.scan_done = hit || (remain_ff == '0 && !rd_vld_ff);

   // scan counter, one slot issued per cycle from the top down
   always_comb begin
      remain_in = remain_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      priority if (cmd.start) begin
         remain_in = limit;
      end else if (cmd.scan && !hit && remain_ff != '0) begin
         remain_in = remain_dec;
         rd_vld_in = 1'b1;
         rd_idx_in = remain_dec[dns_pkg::ADDR_W-1:0];
      end else begin
         remain_in = remain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // query, slot tag, result and output registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (cmd.start) begin
         query_ff <= req_name_bytes;
      end
      if (cmd.capture) begin
         res_found_ff <= hit;
         res_idx_ff   <= hit ? rd_idx_ff : '0;
      end
      if (cmd.load_out) begin
         out_found_ff <= res_found_ff;
         out_idx_ff   <= res_idx_ff;
      end
   end

   assign rsp_found       = out_found_ff;
   assign rsp_match_index = out_idx_ff;

endmodule

>>> hw/rtl/directory_name_search.sv
`timescale 1ns / 1ps

// channel    direction  handshake       payload
// req_chan   in         valid / ready   func, entry_index, name_bytes
// rsp_chan   out        valid / ready   found, match_index
// csr        in         csr_wr_en       csr_wr_data (entry_count)
//
// a write is taken in the idle state; a search reads one stored name per cycle from slot n-1
// down (n = entry_count, saturated to 2048) and shows its result once a slot read matches,
// or once all n slots are read when none does; when n is 0 no slot is read.
// reset clears control and entry_count; the name memory is not cleared.
// while a result waits on rsp_chan the block still takes writes and one search;
// that search's result then waits in the hold state with the input stalled.

module directory_name_search (
   input  logic                        clock,
   input  logic                        reset,
   dns_req_if.sink                     req_chan,
   dns_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [dns_pkg::COUNT_W-1:0] csr_wr_data
);

   dns_pkg::cmd_type cmd;
   dns_pkg::sts_type sts;

   // control
   dns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // name store and compare
   dns_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_entry_index (req_chan.entry_index),
      .req_name_bytes  (req_chan.name_bytes),
      .rsp_found       (rsp_chan.found),
      .rsp_match_index (rsp_chan.match_index),
      .cmd             (cmd),
      .sts             (sts)
   );

`ifndef ASSERT_OFF
   // a not-found result carries index zero
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |-> rsp_chan.match_index == '0)
      else $error("not-found result with nonzero index");

   // a search transfer makes the block busy in the next cycle
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.func == dns_pkg::FUNC_SEARCH
      |=> !req_chan.ready)
      else $error("input taken during a search");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   // a write transfer never raises a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.func == dns_pkg::FUNC_WRITE
      && !rsp_chan.valid |=> !rsp_chan.valid)
      else $error("result raised by a write");
`endif

endmodule
